[design/ua_tcp_dfr_pkg.sv]
// Shared types and constants for the transport chunk deframer.
// Used by the step logic and the top level; depends on nothing else.

package ua_tcp_dfr_pkg;

    localparam logic [31:0] HEADER_BYTES    = 32'd8;
    localparam logic [31:0] MAX_CHUNK_RESET = 32'd65536;

    typedef enum logic [2:0] {
        KIND_HEL = 3'd0,
        KIND_ACK = 3'd1,
        KIND_ERR = 3'd2,
        KIND_MSG = 3'd3,
        KIND_OPN = 3'd4,
        KIND_CLO = 3'd5,
        KIND_BAD = 3'd7
    } msg_kind_t;

    typedef enum logic [1:0] {
        FLAG_C   = 2'd0,
        FLAG_F   = 2'd1,
        FLAG_A   = 2'd2,
        FLAG_BAD = 2'd3
    } chunk_flag_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_TYPE  = 2'd1,
        ERR_TOO_LARGE = 2'd2,
        ERR_TOO_SMALL = 2'd3
    } dfr_error_t;

    typedef struct packed {
        logic [31:0] pos;
        logic [15:0] type_letters;
        msg_kind_t   kind;
        chunk_flag_t flag;
        logic [31:0] size;
        dfr_error_t  err;
    } dfr_state_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        in_header;
        logic [31:0] byte_offset;
        logic [2:0]  msg_kind;
        logic [1:0]  chunk_kind;
        logic        last_of_chunk;
        logic [1:0]  error_code;
    } dfr_result_t;

endpackage

[design/ua_tcp_dfr_in_stage.sv]
// Input register of the deframer: holds one accepted byte until the step logic takes it.
// Stand-alone; no package needed.

module ua_tcp_dfr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       s1_valid,
    output logic [7:0] s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The stage can refill in the same cycle that its byte moves on.
    assign rx_ready   = !valid_reg || take;
    assign valid_next = (rx_valid && rx_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule

[design/ua_tcp_dfr_step.sv]
// Per-byte step logic: header capture, header checks, body counting and chunk end.
// Depends on ua_tcp_dfr_pkg.

module ua_tcp_dfr_step (
    input  ua_tcp_dfr_pkg::dfr_state_t  st,
    input  logic [7:0]                  rx_byte,
    input  logic [31:0]                 size_limit,
    output ua_tcp_dfr_pkg::dfr_state_t  st_next,
    output ua_tcp_dfr_pkg::dfr_result_t res
);

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;

    function automatic ua_tcp_dfr_pkg::msg_kind_t decode_kind(
        input logic [15:0] first_two,
        input logic [7:0]  third
    );
        ua_tcp_dfr_pkg::msg_kind_t k;
        k = ua_tcp_dfr_pkg::KIND_BAD;
        if (first_two == {CH_H, CH_E} && third == CH_L)
            k = ua_tcp_dfr_pkg::KIND_HEL;
        else if (first_two == {CH_A, CH_C} && third == CH_K)
            k = ua_tcp_dfr_pkg::KIND_ACK;
        else if (first_two == {CH_E, CH_R} && third == CH_R)
            k = ua_tcp_dfr_pkg::KIND_ERR;
        else if (first_two == {CH_M, CH_S} && third == CH_G)
            k = ua_tcp_dfr_pkg::KIND_MSG;
        else if (first_two == {CH_O, CH_P} && third == CH_N)
            k = ua_tcp_dfr_pkg::KIND_OPN;
        else if (first_two == {CH_C, CH_L} && third == CH_O)
            k = ua_tcp_dfr_pkg::KIND_CLO;
        return k;
    endfunction

    function automatic ua_tcp_dfr_pkg::chunk_flag_t decode_flag(input logic [7:0] b);
        ua_tcp_dfr_pkg::chunk_flag_t f;
        f = ua_tcp_dfr_pkg::FLAG_BAD;
        if (b == CH_C)
            f = ua_tcp_dfr_pkg::FLAG_C;
        else if (b == CH_F)
            f = ua_tcp_dfr_pkg::FLAG_F;
        else if (b == CH_A)
            f = ua_tcp_dfr_pkg::FLAG_A;
        return f;
    endfunction

    logic                         hdr;
    logic                         pos_ge2;
    logic                         pos_ge3;
    logic                         pos_ge7;
    logic                         pos_is7;
    logic [31:0]                  pos_inc;
    logic [15:0]                  letters_now;
    ua_tcp_dfr_pkg::msg_kind_t    kind_now;
    ua_tcp_dfr_pkg::chunk_flag_t  flag_now;
    logic [31:0]                  size_now;
    ua_tcp_dfr_pkg::dfr_error_t   hdr_err;
    logic                         last;

    assign hdr     = (st.pos[31:3] == 29'd0);
    assign pos_ge2 = !hdr || (st.pos[2:1] != 2'd0);
    assign pos_ge3 = !hdr || (st.pos[2:0] >= 3'd3);
    assign pos_is7 = (st.pos == (ua_tcp_dfr_pkg::HEADER_BYTES - 32'd1));
    assign pos_ge7 = !hdr || pos_is7;
    assign pos_inc = st.pos + 32'd1;

    always_comb
    begin
        letters_now = st.type_letters;
        kind_now    = st.kind;
        flag_now    = st.flag;
        size_now    = st.size;
        if (hdr)
        begin
            unique case (st.pos[2:0])
                3'd0: letters_now = {rx_byte, 8'd0};
                3'd1: letters_now = {st.type_letters[15:8], rx_byte};
                3'd2: kind_now = decode_kind(st.type_letters, rx_byte);
                3'd3:
                begin
                    flag_now = decode_flag(rx_byte);
                    size_now = 32'd0;
                end
                default: size_now = st.size | ({24'd0, rx_byte} << {st.pos[1:0], 3'b000});
            endcase
        end
    end

    // All header checks land on the last header byte, in priority order.
    always_comb
    begin
        if (kind_now == ua_tcp_dfr_pkg::KIND_BAD || flag_now == ua_tcp_dfr_pkg::FLAG_BAD ||
            (kind_now != ua_tcp_dfr_pkg::KIND_MSG && flag_now != ua_tcp_dfr_pkg::FLAG_F))
            hdr_err = ua_tcp_dfr_pkg::ERR_BAD_TYPE;
        else if (size_now > size_limit)
            hdr_err = ua_tcp_dfr_pkg::ERR_TOO_LARGE;
        else if (size_now < ua_tcp_dfr_pkg::HEADER_BYTES)
            hdr_err = ua_tcp_dfr_pkg::ERR_TOO_SMALL;
        else
            hdr_err = ua_tcp_dfr_pkg::ERR_NONE;
    end

    assign last = pos_ge7 && (pos_inc == size_now);

    always_comb
    begin
        st_next          = st;
        res.byte_out     = rx_byte;
        res.in_header    = 1'b0;
        res.byte_offset  = 32'd0;
        res.msg_kind     = 3'd0;
        res.chunk_kind   = 2'd0;
        res.last_of_chunk = 1'b0;
        res.error_code   = st.err;
        if (st.err == ua_tcp_dfr_pkg::ERR_NONE)
        begin
            st_next.type_letters = letters_now;
            st_next.kind         = kind_now;
            st_next.flag         = flag_now;
            st_next.size         = size_now;
            res.in_header        = hdr;
            res.byte_offset      = st.pos;
            if (pos_ge2 && kind_now != ua_tcp_dfr_pkg::KIND_BAD)
                res.msg_kind = kind_now;
            if (pos_ge3 && flag_now != ua_tcp_dfr_pkg::FLAG_BAD)
                res.chunk_kind = flag_now;
            if (pos_is7 && hdr_err != ua_tcp_dfr_pkg::ERR_NONE)
            begin
                // The position stays put; the state is frozen from here on.
                st_next.err    = hdr_err;
                res.error_code = hdr_err;
            end
            else
            begin
                res.last_of_chunk = last;
                st_next.pos       = last ? 32'd0 : pos_inc;
            end
        end
    end

endmodule

[design/ua_tcp_chunk_deframer_core.sv]
// Top level of the transport chunk deframer: input register, step logic, state and
// result register. Depends on ua_tcp_dfr_pkg, ua_tcp_dfr_in_stage and ua_tcp_dfr_step.
//
//  Channel   Handshake                Payload
//  rx        rx_valid / rx_ready      rx_byte
//  out       out_valid / out_ready    byte_out, in_header, byte_offset, msg_kind,
//                                     chunk_kind, last_of_chunk, error_code
//  cfg       cfg_we                   cfg_wdata (max_chunk_size)
//
// One byte per clock is sustained while out_ready stays high; each byte passes the input
// register and then the result register before its result is presented.
// The chunk state and result register advance together through one pass of step logic.
// Reset clears the chunk state and any error and loads max_chunk_size with 65536.
// An output stall holds the result register; the input register still takes a byte if it is empty.

module ua_tcp_chunk_deframer_core #(
    parameter logic [31:0] MAX_CHUNK_RESET = ua_tcp_dfr_pkg::MAX_CHUNK_RESET
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic        in_header,
    output logic [31:0] byte_offset,
    output logic [2:0]  msg_kind,
    output logic [1:0]  chunk_kind,
    output logic        last_of_chunk,
    output logic [1:0]  error_code,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic                        s1_valid;
    logic [7:0]                  s1_byte;
    logic                        advance;
    logic                        take;
    logic [31:0]                 size_limit_reg;
    ua_tcp_dfr_pkg::dfr_state_t  st_reg;
    ua_tcp_dfr_pkg::dfr_state_t  st_next;
    ua_tcp_dfr_pkg::dfr_result_t res_next;
    ua_tcp_dfr_pkg::dfr_result_t res_reg;
    logic                        out_valid_reg;

    assign advance = !out_valid_reg || out_ready;
    assign take    = s1_valid && advance;

    ua_tcp_dfr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    ua_tcp_dfr_step u_step (
        .st         (st_reg),
        .rx_byte    (s1_byte),
        .size_limit (size_limit_reg),
        .st_next    (st_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg <= MAX_CHUNK_RESET;
            st_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_limit_reg <= cfg_wdata;
            end
            if (take)
            begin
                st_reg        <= st_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_out      = res_reg.byte_out;
    assign in_header     = res_reg.in_header;
    assign byte_offset   = res_reg.byte_offset;
    assign msg_kind      = res_reg.msg_kind;
    assign chunk_kind    = res_reg.chunk_kind;
    assign last_of_chunk = res_reg.last_of_chunk;
    assign error_code    = res_reg.error_code;

    // Once set, the error code never changes until reset.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.err != ua_tcp_dfr_pkg::ERR_NONE |=> st_reg.err == $past(st_reg.err))
        else $error("sticky error changed");

    // A chunk end is never reported together with an error.
    a_last_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_chunk |-> error_code == ua_tcp_dfr_pkg::ERR_NONE)
        else $error("chunk end reported with an error");

    // Header bytes always sit at the front of a chunk.
    a_header_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_header |-> byte_offset < ua_tcp_dfr_pkg::HEADER_BYTES)
        else $error("header byte beyond header length");

    // The byte after a chunk end starts the next chunk at offset zero.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_next.last_of_chunk |=> st_reg.pos == 32'd0)
        else $error("position not cleared after chunk end");

    // An empty result register never holds back the input.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> rx_ready)
        else $error("input stalled while output is empty");

endmodule

[test/testbench.sv]
// Self-checking testbench for ua_tcp_chunk_deframer_core.
// It drives well-formed and broken transport chunks and checks every result against a prediction.
// Depends on ua_tcp_dfr_pkg and the deframer RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_OFF_AT = 500;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_BYTES = 320;

    localparam logic [7:0] LETTER_C = "C";
    localparam logic [7:0] LETTER_F = "F";
    localparam logic [7:0] LETTER_A = "A";

    typedef enum int {
        BREAK_LETTERS,
        BREAK_FLAG,
        BREAK_FLAG_RULE,
        BREAK_OVERSIZE,
        BREAK_UNDERSIZE
    } header_fault_t;

    // Tracks the chunk state of the deframer and holds the results it must produce.
    class deframe_tracker;
        ua_tcp_dfr_pkg::dfr_result_t pending_results[$];
        int                          mismatches;
        logic [31:0]                 size_limit;
        logic [31:0]                 offset;
        logic [15:0]                 letters;
        ua_tcp_dfr_pkg::msg_kind_t   kind;
        ua_tcp_dfr_pkg::chunk_flag_t flag;
        logic [31:0]                 declared;
        ua_tcp_dfr_pkg::dfr_error_t  latched_fault;

        function new();
            mismatches    = 0;
            size_limit    = ua_tcp_dfr_pkg::MAX_CHUNK_RESET;
            offset        = '0;
            letters       = '0;
            kind          = ua_tcp_dfr_pkg::KIND_HEL;
            flag          = ua_tcp_dfr_pkg::FLAG_C;
            declared      = '0;
            latched_fault = ua_tcp_dfr_pkg::ERR_NONE;
        endfunction

        function void set_size_limit(logic [31:0] value);
            size_limit = value;
        endfunction

        function ua_tcp_dfr_pkg::msg_kind_t decode_kind(logic [15:0] pair, logic [7:0] third);
            if (pair == {"H", "E"} && third == "L") return ua_tcp_dfr_pkg::KIND_HEL;
            if (pair == {"A", "C"} && third == "K") return ua_tcp_dfr_pkg::KIND_ACK;
            if (pair == {"E", "R"} && third == "R") return ua_tcp_dfr_pkg::KIND_ERR;
            if (pair == {"M", "S"} && third == "G") return ua_tcp_dfr_pkg::KIND_MSG;
            if (pair == {"O", "P"} && third == "N") return ua_tcp_dfr_pkg::KIND_OPN;
            if (pair == {"C", "L"} && third == "O") return ua_tcp_dfr_pkg::KIND_CLO;
            return ua_tcp_dfr_pkg::KIND_BAD;
        endfunction

        function ua_tcp_dfr_pkg::chunk_flag_t decode_flag(logic [7:0] letter);
            if (letter == LETTER_C) return ua_tcp_dfr_pkg::FLAG_C;
            if (letter == LETTER_F) return ua_tcp_dfr_pkg::FLAG_F;
            if (letter == LETTER_A) return ua_tcp_dfr_pkg::FLAG_A;
            return ua_tcp_dfr_pkg::FLAG_BAD;
        endfunction

        function void take_byte(logic [7:0] b);
            ua_tcp_dfr_pkg::dfr_result_t r;
            ua_tcp_dfr_pkg::dfr_error_t  fault;
            r = '0;
            r.byte_out = b;
            fault = ua_tcp_dfr_pkg::ERR_NONE;
            // Once a header has failed, the stream is only passed through.
            if (latched_fault != ua_tcp_dfr_pkg::ERR_NONE) begin
                r.error_code = latched_fault;
                pending_results.push_back(r);
                return;
            end
            if (offset < ua_tcp_dfr_pkg::HEADER_BYTES) begin
                r.in_header = 1'b1;
                case (offset)
                    32'd0: letters = {b, 8'h00};
                    32'd1: letters[7:0] = b;
                    32'd2: kind = decode_kind(letters, b);
                    32'd3:
                    begin
                        flag = decode_flag(b);
                        declared = '0;
                    end
                    default: declared = declared | ({24'h0, b} << (8 * (offset - 32'd4)));
                endcase
            end
            r.byte_offset = offset;
            if (offset >= 32'd2 && kind != ua_tcp_dfr_pkg::KIND_BAD) r.msg_kind = kind;
            if (offset >= 32'd3 && flag != ua_tcp_dfr_pkg::FLAG_BAD) r.chunk_kind = flag;
            if (offset == ua_tcp_dfr_pkg::HEADER_BYTES - 32'd1) begin
                if (kind == ua_tcp_dfr_pkg::KIND_BAD || flag == ua_tcp_dfr_pkg::FLAG_BAD ||
                    (kind != ua_tcp_dfr_pkg::KIND_MSG && flag != ua_tcp_dfr_pkg::FLAG_F))
                    fault = ua_tcp_dfr_pkg::ERR_BAD_TYPE;
                else if (declared > size_limit)
                    fault = ua_tcp_dfr_pkg::ERR_TOO_LARGE;
                else if (declared < ua_tcp_dfr_pkg::HEADER_BYTES)
                    fault = ua_tcp_dfr_pkg::ERR_TOO_SMALL;
            end
            if (fault != ua_tcp_dfr_pkg::ERR_NONE) begin
                latched_fault = fault;
                r.error_code = fault;
            end
            else if (offset >= ua_tcp_dfr_pkg::HEADER_BYTES - 32'd1 &&
                     offset == declared - 32'd1) begin
                r.last_of_chunk = 1'b1;
                offset = '0;
            end
            else begin
                offset = offset + 32'd1;
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, actual %0h", field, want, seen);
                mismatches++;
            end
        endfunction

        function void match_result(ua_tcp_dfr_pkg::dfr_result_t got);
            ua_tcp_dfr_pkg::dfr_result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: byte_out %0h", got.byte_out);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("byte_out", want.byte_out, got.byte_out);
            compare_field("in_header", want.in_header, got.in_header);
            compare_field("byte_offset", want.byte_offset, got.byte_offset);
            compare_field("msg_kind", want.msg_kind, got.msg_kind);
            compare_field("chunk_kind", want.chunk_kind, got.chunk_kind);
            compare_field("last_of_chunk", want.last_of_chunk, got.last_of_chunk);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  byte_out;
    logic        in_header;
    logic [31:0] byte_offset;
    logic [2:0]  msg_kind;
    logic [1:0]  chunk_kind;
    logic        last_of_chunk;
    logic [1:0]  error_code;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    deframe_tracker tracker = new();

    logic [23:0] kind_letters [6] = '{"HEL", "ACK", "ERR", "MSG", "OPN", "CLO"};
    logic [7:0]  flag_letters [3] = '{"C", "F", "A"};

    bit sender_burst = 1'b0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    ua_tcp_chunk_deframer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_out      (byte_out),
        .in_header     (in_header),
        .byte_offset   (byte_offset),
        .msg_kind      (msg_kind),
        .chunk_kind    (chunk_kind),
        .last_of_chunk (last_of_chunk),
        .error_code    (error_code),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((rx_valid && rx_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        tracker.take_byte(b);
        bytes_sent++;
        if (bytes_sent % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_header(logic [23:0] letters, logic [7:0] flag_letter, logic [31:0] size);
        send_byte(letters[23:16]);
        send_byte(letters[15:8]);
        send_byte(letters[7:0]);
        send_byte(flag_letter);
        send_byte(size[7:0]);
        send_byte(size[15:8]);
        send_byte(size[23:16]);
        send_byte(size[31:24]);
    endtask

    task automatic send_chunk(logic [23:0] letters, logic [7:0] flag_letter, logic [31:0] size);
        logic [31:0] i;
        send_header(letters, flag_letter, size);
        for (i = ua_tcp_dfr_pkg::HEADER_BYTES; i < size; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_chunk();
        int          k;
        logic [7:0]  flag_letter;
        logic [31:0] cap;
        logic [31:0] size;
        k = $urandom_range(0, 1) ? int'(ua_tcp_dfr_pkg::KIND_MSG) : $urandom_range(0, 5);
        flag_letter = (k == int'(ua_tcp_dfr_pkg::KIND_MSG)) ?
                      flag_letters[$urandom_range(0, 2)] : LETTER_F;
        cap = (tracker.size_limit < 32'd64) ? tracker.size_limit : 32'd64;
        size = ($urandom_range(0, 7) == 0) ? cap :
               $urandom_range(ua_tcp_dfr_pkg::HEADER_BYTES, cap);
        send_chunk(kind_letters[k], flag_letter, size);
    endtask

    task automatic run_phase(int nbytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) send_random_chunk();
    endtask

    // The register is only written with the pipeline drained.
    task automatic write_size_limit(logic [31:0] value);
        rx_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_size_limit(value);
    endtask

    task automatic send_faulty_chunk();
        header_fault_t pick;
        int            k;
        logic [23:0]   letters;
        logic [7:0]    flag_letter;
        logic [31:0]   size;
        pick = header_fault_t'($urandom_range(0, 4));
        k = $urandom_range(0, 5);
        letters = kind_letters[k];
        flag_letter = (k == int'(ua_tcp_dfr_pkg::KIND_MSG)) ?
                      flag_letters[$urandom_range(0, 2)] : LETTER_F;
        size = $urandom_range(ua_tcp_dfr_pkg::HEADER_BYTES, 32);
        case (pick)
            BREAK_LETTERS:
            begin
                // No two type names share two letters, so one corrupted letter is never valid.
                letters = letters ^ (24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2)));
            end
            BREAK_FLAG:
            begin
                do flag_letter = 8'($urandom_range(0, 255));
                while (flag_letter == LETTER_C || flag_letter == LETTER_F ||
                       flag_letter == LETTER_A);
            end
            BREAK_FLAG_RULE:
            begin
                k = $urandom_range(0, 4);
                if (k >= int'(ua_tcp_dfr_pkg::KIND_MSG)) k++;
                letters = kind_letters[k];
                flag_letter = $urandom_range(0, 1) ? LETTER_C : LETTER_A;
            end
            BREAK_OVERSIZE: size = $urandom_range(tracker.size_limit + 32'd1, 32'hFFFF_FFFF);
            BREAK_UNDERSIZE: size = $urandom_range(0, ua_tcp_dfr_pkg::HEADER_BYTES - 1);
            default: ;
        endcase
        send_header(letters, flag_letter, size);
    endtask

    initial
    begin
        ua_tcp_dfr_pkg::dfr_result_t got;
        int                          n;
        int                          results_seen;
        bit                          recv_burst;
        results_seen = 0;
        recv_burst = 1'b0;
        out_ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (results_seen == HOLD_OFF_AT)
                n = HOLD_OFF_CYCLES;
            else
                n = recv_burst ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.byte_out      = byte_out;
            got.in_header     = in_header;
            got.byte_offset   = byte_offset;
            got.msg_kind      = msg_kind;
            got.chunk_kind    = chunk_kind;
            got.last_of_chunk = last_of_chunk;
            got.error_code    = error_code;
            tracker.match_result(got);
            results_seen++;
            if (results_seen % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        rx_valid  = 1'b0;
        rx_byte   = 8'h00;
        cfg_we    = 1'b0;
        cfg_wdata = 32'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every type with its legal flags, header-only chunks, and extreme body bytes.
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_HEL], LETTER_F, 32'd8);
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_ACK], LETTER_F, 32'd8);
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_ERR], LETTER_F, 32'd8);
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_OPN], LETTER_F, 32'd8);
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_CLO], LETTER_F, 32'd8);
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_MSG], LETTER_C, 32'd8);
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_MSG], LETTER_A, 32'd8);
        send_header(kind_letters[ua_tcp_dfr_pkg::KIND_MSG], LETTER_F, 32'd10);
        send_byte(8'h00);
        send_byte(8'hFF);

        write_size_limit(32'd9);
        run_phase(PHASE_BYTES);
        write_size_limit(32'hFFFF_FFFF);
        run_phase(PHASE_BYTES);
        write_size_limit(32'd24);
        run_phase(PHASE_BYTES);
        write_size_limit($urandom_range(9, 200));
        run_phase(PHASE_BYTES);
        write_size_limit(ua_tcp_dfr_pkg::MAX_CHUNK_RESET);
        run_phase(PHASE_BYTES);

        // The error is sticky until reset, so the single broken header comes last.
        write_size_limit($urandom_range(9, 4096));
        run_phase(40);
        send_faulty_chunk();
        repeat (60) send_byte(8'($urandom_range(0, 255)));

        rx_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
